[sv/assert_macros.svh]
// assertion helpers, clocked on clk_i, off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TSPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define TSPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tsps_pkg.sv]
package tsps_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned VALUE_BITS_DEF  = 24;
  localparam int unsigned LEN_W           = 9;
  localparam logic [LEN_W-1:0] LEN_RESET  = 9'd256;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned CFG_IDX_W       = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE  = 2'd0,
    FN_TARGET = 2'd1,
    FN_TICK   = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_LENGTH = 2'd0,
    CFG_START_VALUE  = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_TICK
  } state_e;

endpackage

[sv/tsps_table.sv]
module tsps_table import tsps_pkg::*; #(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned WIDTH = VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/table_stepped_parameter_smoother.sv]
// channel   direction  handshake                         payload
// request   in         start_i high while busy_o low     func_i, entry_index_i, value_i
// result    out        result_strobe_o, one cycle        sample_o, ramping_o
// config    in         cfg_we_i, taken at once           cfg_index_i, cfg_data_i
//
// tick needing a table step: ST_TICK waits on the registered table read port
// other ticks and table writes: done in ST_IDLE; set target: ST_COUNT over the used length,
// one entry read and compared per cycle through the single read port
// result strobe is registered from the step that ends a tick; receiver cannot stall
// reset: current, target and positions zero, table length 256, table contents undefined
module table_stepped_parameter_smoother import tsps_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = (VALUE_BITS > LEN_W) ? VALUE_BITS : LEN_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [FUNC_W-1:0]            func_i,
  input  logic [AW-1:0]                entry_index_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         result_strobe_o,
  output logic signed [VALUE_BITS-1:0] sample_o,
  output logic                         ramping_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CW-1:0]                cfg_data_i
);

  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = (PW > LEN_W) ? PW : LEN_W;

  state_e state_q, state_d;

  logic signed [VALUE_BITS-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic signed [VALUE_BITS-1:0] sample_q, sample_d, rd_data, cfg_value;
  logic [PW-1:0]    cp_q, cp_d, tp_q, tp_d;
  logic [PW-1:0]    cnt_q, cnt_d, ccnt_q, ccnt_d, tcnt_q, tcnt_d;
  logic [PW-1:0]    used_len, tick_addr;
  logic [LEN_W-1:0] len_q, len_d;
  logic [NW-1:0]    len_ext;
  logic             up_q, up_d, rdv_q, rdv_d;
  logic             ramp_q, ramp_d, strobe_q, strobe_d;
  logic             accept, issue, hit_cur, hit_tgt, tbl_we;
  logic [AW-1:0]    rd_addr;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);
  assign cfg_value = cfg_data_i[VALUE_BITS-1:0];

  // entries in use
  assign len_ext  = NW'(len_q);
  assign used_len = (len_ext < NW'(TABLE_DEPTH)) ? PW'(len_ext) : PW'(TABLE_DEPTH);
  assign issue    = (cnt_q < used_len);

  assign tick_addr = (cp_q < tp_q) ? cp_q : cp_q - 1'b1;
  assign rd_addr   = (state_q == ST_COUNT) ? cnt_q[AW-1:0] : tick_addr[AW-1:0];
  assign tbl_we    = accept && (func_i == FN_WRITE) &&
                     (PW'(entry_index_i) < PW'(TABLE_DEPTH));

  // rising target counts entries <= value, falling counts entries < value
  assign hit_cur = (rd_data < cur_q) || (up_q && (rd_data == cur_q));
  assign hit_tgt = (rd_data < tgt_q) || (up_q && (rd_data == tgt_q));

  tsps_table #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(VALUE_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (entry_index_i),
    .wdata_i (value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FN_TARGET) && (value_i != cur_q)) begin
          state_d = ST_COUNT;
        end else if (accept && (func_i == FN_TICK) && (cur_q != tgt_q) &&
                     (cp_q != tp_q)) begin
          state_d = ST_TICK;
        end
      end
      ST_COUNT: begin
        if (!issue && !rdv_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d    = cur_q;
    tgt_d    = tgt_q;
    cp_d     = cp_q;
    tp_d     = tp_q;
    len_d    = len_q;
    up_d     = up_q;
    cnt_d    = cnt_q;
    ccnt_d   = ccnt_q;
    tcnt_d   = tcnt_q;
    rdv_d    = 1'b0;
    sample_d = sample_q;
    ramp_d   = ramp_q;
    strobe_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FN_TARGET)) begin
          tgt_d  = value_i;
          up_d   = (value_i > cur_q);
          cnt_d  = '0;
          ccnt_d = '0;
          tcnt_d = '0;
        end else if (accept && (func_i == FN_TICK)) begin
          if (cur_q == tgt_q) begin
            sample_d = cur_q;
            ramp_d   = 1'b0;
            strobe_d = 1'b1;
          end else if (cp_q == tp_q) begin
            sample_d = tgt_q;
            cur_d    = tgt_q;
            ramp_d   = 1'b0;
            strobe_d = 1'b1;
          end else begin
            cp_d = (cp_q < tp_q) ? cp_q + 1'b1 : cp_q - 1'b1;
          end
        end
      end
      ST_COUNT: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        rdv_d = issue;
        if (rdv_q && hit_cur) begin
          ccnt_d = ccnt_q + 1'b1;
        end
        if (rdv_q && hit_tgt) begin
          tcnt_d = tcnt_q + 1'b1;
        end
        if (!issue && !rdv_q) begin
          cp_d = ccnt_q;
          tp_d = tcnt_q;
        end
      end
      ST_TICK: begin
        sample_d = rd_data;
        strobe_d = 1'b1;
        if (cp_q == tp_q) begin
          cur_d  = tgt_q;
          ramp_d = 1'b0;
        end else begin
          cur_d  = rd_data;
          ramp_d = (rd_data != tgt_q);
        end
      end
      default: ;
    endcase
    if (cfg_we_i && (cfg_index_i == CFG_TABLE_LENGTH)) begin
      len_d = cfg_data_i[LEN_W-1:0];
    end else if (cfg_we_i && (cfg_index_i == CFG_START_VALUE)) begin
      cur_d = cfg_value;
      tgt_d = cfg_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_q    <= '0;
      tgt_q    <= '0;
      cp_q     <= '0;
      tp_q     <= '0;
      len_q    <= LEN_RESET;
      up_q     <= 1'b0;
      rdv_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      tgt_q    <= tgt_d;
      cp_q     <= cp_d;
      tp_q     <= tp_d;
      len_q    <= len_d;
      up_q     <= up_d;
      rdv_q    <= rdv_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    ccnt_q   <= ccnt_d;
    tcnt_q   <= tcnt_d;
    sample_q <= sample_d;
    ramp_q   <= ramp_d;
  end

  assign result_strobe_o = strobe_q;
  assign sample_o        = sample_q;
  assign ramping_o       = ramp_q;

endmodule

[sv/tsps_checker.sv]
`include "assert_macros.svh"

module tsps_checker import tsps_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = (VALUE_BITS > LEN_W) ? VALUE_BITS : LEN_W
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [FUNC_W-1:0]            func_i,
  input logic [AW-1:0]                entry_index_i,
  input logic signed [VALUE_BITS-1:0] value_i,
  input logic                         result_strobe_o,
  input logic signed [VALUE_BITS-1:0] sample_o,
  input logic                         ramping_o,
  input logic                         cfg_we_i,
  input logic [CFG_IDX_W-1:0]         cfg_index_i,
  input logic [CW-1:0]                cfg_data_i
);

  logic acc_tick, acc_other;

  assign acc_tick  = start_i && !busy_o && (func_i == FN_TICK);
  assign acc_other = start_i && !busy_o && (func_i != FN_TICK);

  // a tick either answers at once or starts a table step
  `TSPS_ASSERT_NXT(a_tick_progress, acc_tick, busy_o || result_strobe_o, "tick stalled")

  // table writes and target changes produce no result
  `TSPS_ASSERT_NXT(a_no_spurious, acc_other, !result_strobe_o, "result without a tick")

  // a tick right after loading a start value returns it, settled
  `TSPS_ASSERT_NXT(a_start_value,
    (cfg_we_i && (cfg_index_i == CFG_START_VALUE) && !busy_o && !start_i) ##1 acc_tick,
    result_strobe_o && !ramping_o && (sample_o == $past(cfg_data_i[VALUE_BITS-1:0], 2)),
    "start value not returned")

endmodule

bind table_stepped_parameter_smoother tsps_checker #(
  .TABLE_DEPTH(TABLE_DEPTH),
  .VALUE_BITS (VALUE_BITS)
) u_tsps_checker (.*);

[verif/tb_table_stepped_parameter_smoother.sv]
module tb_table_stepped_parameter_smoother;
  timeunit 1ns;
  timeprecision 1ps;

  import tsps_pkg::*;

  localparam int unsigned TD = TABLE_DEPTH_DEF;
  localparam int unsigned VW = VALUE_BITS_DEF;
  localparam int unsigned AW = $clog2(TD);
  localparam int unsigned CW = (VW > LEN_W) ? VW : LEN_W;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int FILL_KEEP     = 0;
  localparam int FILL_SORTED   = 1;
  localparam int FILL_SHUFFLED = 2;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic                 hold;
    logic [FUNC_W-1:0]    fn;
    logic [AW-1:0]        idx;
    logic signed [VW-1:0] val;
  } request_t;

  typedef struct packed {
    logic signed [VW-1:0] sample;
    logic                 ramping;
  } tick_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [FUNC_W-1:0]    func_i = '0;
  logic [AW-1:0]        entry_index_i = '0;
  logic signed [VW-1:0] value_i = '0;
  logic                 result_strobe_o;
  logic signed [VW-1:0] sample_o;
  logic                 ramping_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CW-1:0]        cfg_data_i = '0;

  table_stepped_parameter_smoother DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .entry_index_i  (entry_index_i),
    .value_i        (value_i),
    .result_strobe_o(result_strobe_o),
    .sample_o       (sample_o),
    .ramping_o      (ramping_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  request_t     request_q[$];
  tick_result_t due_samples[$];
  request_t     next_request;
  tick_result_t due_result;
  int unsigned  queued_count = 0;
  int unsigned  accepted_count = 0;
  int unsigned  idle_pct = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;

  // smoother state as modelled by the testbench for the result monitor
  logic signed [VW-1:0] step_table[TD];
  logic signed [VW-1:0] level_now = '0;
  logic signed [VW-1:0] level_goal = '0;
  int unsigned          pos_now = 0;
  int unsigned          pos_goal = 0;
  logic [LEN_W-1:0]     len_reg = LEN_RESET;

  // stimulus-side view of the table
  logic signed [VW-1:0] gen_table[TD];
  logic signed [VW-1:0] goal_hint = '0;

  function automatic int unsigned count_levels(input logic signed [VW-1:0] lvl,
                                               input bit strict_less);
    int unsigned n;
    int unsigned c;
    int unsigned i;
    n = (len_reg > TD) ? TD : int'(len_reg);
    c = 0;
    for (i = 0; i < n; i++) begin
      if (strict_less ? (step_table[i] < lvl) : (step_table[i] <= lvl)) c++;
    end
    return c;
  endfunction

  task automatic advance_smoother(input logic [FUNC_W-1:0] fn, input logic [AW-1:0] idx,
                                  input logic signed [VW-1:0] val);
    logic signed [VW-1:0] smp;
    bit                   moved;
    tick_result_t         r;
    case (fn)
      FN_WRITE: step_table[idx] = val;
      FN_TARGET: begin
        level_goal = val;
        if (level_now < level_goal) begin
          pos_now  = count_levels(level_now, 1'b0);
          pos_goal = count_levels(level_goal, 1'b0);
        end else if (level_goal < level_now) begin
          pos_now  = count_levels(level_now, 1'b1);
          pos_goal = count_levels(level_goal, 1'b1);
        end
      end
      FN_TICK: begin
        if (level_now != level_goal) begin
          moved = 1'b0;
          smp = level_goal;
          if (pos_now < pos_goal) begin
            smp = step_table[pos_now];
            pos_now++;
            moved = 1'b1;
          end else if (pos_goal < pos_now) begin
            pos_now--;
            smp = step_table[pos_now];
            moved = 1'b1;
          end
          if (pos_now == pos_goal) begin
            level_now = level_goal;
            if (!moved) smp = level_now;
          end else begin
            level_now = smp;
          end
        end else begin
          smp = level_now;
        end
        r.sample  = smp;
        r.ramping = (level_now != level_goal);
        due_samples.push_back(r);
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i       <= 1'b0;
      func_i        <= '0;
      entry_index_i <= '0;
      value_i       <= '0;
    end else begin
      if (start_i && !busy_o) begin
        advance_smoother(func_i, entry_index_i, value_i);
        accepted_count++;
      end
      if (!start_i || !busy_o) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
            !(request_q[0].hold && due_samples.size() != 0)) begin
          next_request   = request_q.pop_front();
          start_i       <= 1'b1;
          func_i        <= next_request.fn;
          entry_index_i <= next_request.idx;
          value_i       <= next_request.val;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (due_samples.size() == 0) begin
        $error("sample: no tick pending, actual %0d", sample_o);
        fail_count++;
      end else begin
        due_result = due_samples.pop_front();
        if (sample_o !== due_result.sample) begin
          $error("sample: expected %0d, actual %0d", $signed(due_result.sample), sample_o);
          fail_count++;
        end
        if (ramping_o !== due_result.ramping) begin
          $error("ramping: expected %0d, actual %0d", due_result.ramping, ramping_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("table_stepped_parameter_smoother verification failed");
      $finish;
    end
  end

  task automatic push_request(input logic [FUNC_W-1:0] fn, input logic [AW-1:0] idx,
                              input logic signed [VW-1:0] val, input logic hold);
    request_t r;
    r.hold = hold;
    r.fn   = fn;
    r.idx  = idx;
    r.val  = val;
    request_q.push_back(r);
    queued_count++;
    if (fn == FN_WRITE) gen_table[idx] = val;
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || due_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_TABLE_LENGTH: len_reg = data[LEN_W-1:0];
      CFG_START_VALUE: begin
        level_now  = data[VW-1:0];
        level_goal = data[VW-1:0];
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [VW-1:0] choose_goal(input int unsigned n);
    logic signed [VW-1:0] g;
    g = VW'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2, 3: if (n != 0) g = gen_table[$urandom_range(0, n - 1)];
      4, 5: begin
        if (n != 0) g = gen_table[$urandom_range(0, n - 1)];
        g = $urandom_range(0, 1) ? g + 1'b1 : g - 1'b1;
      end
      8: g = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      9: g = goal_hint;
      default: ;
    endcase
    goal_hint = g;
    return g;
  endfunction

  task automatic fill_table(input int unsigned n, input bit sorted);
    longint      lvl;
    longint      stride;
    int unsigned i;
    case ($urandom_range(0, 2))
      0: lvl = longint'(VAL_MIN);
      1: lvl = longint'($signed(VW'($urandom())));
      default: lvl = -longint'($urandom_range(0, 2000));
    endcase
    stride = (longint'(VAL_MAX) - lvl) / longint'(n + 1);
    for (i = 0; i < n; i++) begin
      if (!sorted) begin
        lvl = longint'($signed(VW'($urandom())));
      end else if (i != 0 && $urandom_range(0, 5) != 0) begin
        lvl += longint'($urandom_range(0, 32'(stride)));
      end
      if (sorted && i == n - 1 && $urandom_range(0, 2) == 0) lvl = longint'(VAL_MAX);
      push_request(FN_WRITE, AW'(i), VW'(lvl), 1'b0);
    end
  endtask

  // mostly target-then-ticks runs, with stray table writes and unused funcs mixed in
  task automatic random_burst(input int unsigned n, input int unsigned quota);
    int unsigned done_cnt;
    int unsigned k;
    int unsigned pick;
    done_cnt = 0;
    while (done_cnt < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        push_request(FN_UNUSED, AW'($urandom()), VW'($urandom()), 1'b0);
      end else if (pick < 12) begin
        push_request(FN_WRITE, AW'($urandom()), VW'($urandom()), 1'b0);
        done_cnt++;
      end else begin
        push_request(FN_TARGET, AW'($urandom()), choose_goal(n), $urandom_range(0, 14) == 0);
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(2, n + 2) : $urandom_range(1, 8);
        repeat (k) push_request(FN_TICK, AW'($urandom()), VW'($urandom()), 1'b0);
        done_cnt += k + 1;
      end
    end
  endtask

  task automatic run_phase(input int unsigned len, input logic signed [VW-1:0] start_val,
                           input int unsigned pct, input int fill_mode,
                           input int unsigned quota);
    logic [CW-1:0] d;
    int unsigned   n;
    wait_drained();
    d = CW'($urandom());
    d[LEN_W-1:0] = LEN_W'(len);
    write_register(CFG_TABLE_LENGTH, d);
    write_register(CFG_START_VALUE, CW'(start_val));
    write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CW'($urandom()));
    idle_pct  = pct;
    goal_hint = start_val;
    n = (len > TD) ? TD : len;
    if (fill_mode != FILL_KEEP) fill_table(n, fill_mode == FILL_SORTED);
    random_burst(n, quota);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset state: still at zero, nothing to read
    push_request(FN_TICK, '0, '0, 1'b0);
    push_request(FN_UNUSED, '1, '1, 1'b0);
    wait_drained();

    write_register(CFG_TABLE_LENGTH, CW'(2));
    write_register(CFG_START_VALUE, '0);
    write_register(CFG_SPARE_A, '1);
    write_register(CFG_SPARE_B, '1);
    idle_pct = 0;

    push_request(FN_WRITE, '0, VAL_MIN, 1'b0);
    push_request(FN_WRITE, AW'(1), VAL_MAX, 1'b0);
    push_request(FN_WRITE, '1, VW'(24'h5a5a5a), 1'b0);
    push_request(FN_TARGET, '0, VAL_MAX, 1'b0);
    push_request(FN_TICK, '0, '0, 1'b0);
    push_request(FN_TICK, '0, '0, 1'b1);
    push_request(FN_TARGET, '0, VAL_MIN, 1'b0);
    push_request(FN_TICK, '0, '0, 1'b0);
    // target equal to current leaves positions alone
    push_request(FN_TARGET, '0, VAL_MIN, 1'b0);
    push_request(FN_TICK, '0, '0, 1'b0);
    // positions already equal, tick jumps straight to target
    push_request(FN_TARGET, '0, VW'(100), 1'b0);
    push_request(FN_TICK, '0, '0, 1'b0);
    push_request(FN_TARGET, '0, -VW'(5), 1'b0);
    push_request(FN_TICK, '0, '0, 1'b0);
    push_request(FN_WRITE, AW'(1), VAL_MIN, 1'b0);
    push_request(FN_TARGET, '1, VAL_MAX, 1'b0);
    push_request(FN_TICK, '1, '1, 1'b0);
    push_request(FN_TICK, '0, '0, 1'b0);

    run_phase(256, VW'($urandom()), 68, FILL_SORTED, 60);
    run_phase(511, VAL_MIN, 0, FILL_KEEP, 30);
    run_phase(5, VAL_MAX, 26, FILL_SORTED, 40);
    run_phase(1, VW'($urandom()), 68, FILL_KEEP, 15);
    run_phase(0, VW'($urandom()), 0, FILL_KEEP, 10);
    run_phase($urandom_range(2, 40), VW'($urandom()), 26, FILL_SHUFFLED, 40);
    run_phase($urandom_range(3, 64), VW'($urandom()), 0, FILL_SORTED, 40);
    run_phase(2, VW'($urandom()), 68, FILL_SORTED, 20);

    wait_drained();
    if (fail_count == 0) begin
      $display("table_stepped_parameter_smoother verification clean");
    end else begin
      $display("table_stepped_parameter_smoother verification failed");
    end
    $finish;
  end

endmodule
